// ===== src/sample_frame_deframer_macros.svh =====
// Assertion macros for the sample frame deframer.
// Uses clk_i and rst_ni of the module that includes it.
`ifndef SAMPLE_FRAME_DEFRAMER_MACROS_SVH
`define SAMPLE_FRAME_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
// General concurrent check on the module clock, off during reset.
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never be true on a clock edge.
`define SFD_ASSERT_NEVER(lbl, cond, msg) \
  `SFD_ASSERT(lbl, !(cond), msg)
`else
`define SFD_ASSERT(lbl, prop, msg)
`define SFD_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/sfd_pkg.sv =====
// Shared types and constants of the sample frame deframer.
// No dependencies.
package sfd_pkg;

  // Event kinds on the result channel.
  typedef enum logic [2:0] {
    EV_STAMP    = 3'd0,
    EV_CHAN     = 3'd1,
    EV_DCHAR    = 3'd2,
    EV_DATA_END = 3'd3,
    EV_STRT_END = 3'd4,
    EV_STOP_END = 3'd5,
    EV_DBG_END  = 3'd6,
    EV_BAD_CMD  = 3'd7
  } ev_kind_e;

  // Register indexes (byte address = 4 * index).
  typedef enum logic [2:0] {
    REG_CHAN_CNT  = 3'd0,
    REG_ON_DEMAND = 3'd1,
    REG_START_OP  = 3'd2,
    REG_STOP_OP   = 3'd3,
    REG_DEBUG_OP  = 3'd4
  } reg_idx_e;

  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned LIM_W   = 5;  // holds channel limits up to 16
  localparam int unsigned Q_DEPTH = 2;  // power of two
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [3:0] CHAN_CNT_RST = 4'd1;
  localparam logic [6:0] START_OP_RST = 7'd1;
  localparam logic [6:0] STOP_OP_RST  = 7'd2;
  localparam logic [6:0] DEBUG_OP_RST = 7'd3;
  localparam logic [6:0] CODE_DATA    = 7'd0;

  typedef struct packed {
    logic [3:0] channel_count;
    logic       on_demand;
    logic [6:0] start_opcode;
    logic [6:0] stop_opcode;
    logic [6:0] debug_opcode;
  } cfg_t;

  typedef struct packed {
    ev_kind_e    kind;
    logic [31:0] value;
    logic [2:0]  chan;
    logic        missed;
    logic        ok;
  } ev_t;

  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

endpackage

// ===== src/sfd_front.sv =====
// Byte parser: tracks frame phase and checksum, emits one event record per result.
// Depends on sfd_pkg.
module sfd_front #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    rx_byte_i,
  input  sfd_pkg::cfg_t cfg_i,
  input  logic          q_full_i,
  output logic          push_valid_o,
  output sfd_pkg::ev_t  push_data_o
);

  localparam int unsigned CNT_W   = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned LIM_W_L = sfd_pkg::LIM_W;

  typedef enum logic [2:0] {
    PH_HEADER, PH_STAMP, PH_CHAN, PH_DLEN, PH_DCHAR, PH_CHECK
  } phase_e;

  typedef enum logic [1:0] {
    FT_DATA, FT_START, FT_STOP, FT_DEBUG
  } ftype_e;

  phase_e           phase_q, phase_d;
  ftype_e           ftype_q, ftype_d;
  logic [1:0]       biw_q, biw_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       dbg_q, dbg_d;
  logic [7:0]       sum_q, sum_d;
  logic [23:0]      asm_q, asm_d;
  logic             missed_q, missed_d;

  logic             accept;
  logic [6:0]       code;
  logic [7:0]       sum_plus;
  logic [7:0]       pc;
  logic [LIM_W_L-1:0] limit;
  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       dbg_dec;
  logic             ev_valid;
  sfd_pkg::ev_t     ev;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign code       = rx_byte_i[6:0];
  assign pc         = 8'(sfd_pkg::popcount8(rx_byte_i));
  assign sum_plus   = sum_q + pc;
  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign dbg_dec    = dbg_q - 8'd1;
  // Counts above the build limit act as the limit.
  assign limit = ({1'b0, cfg_i.channel_count} > LIM_W_L'(MAX_CHANNELS))
               ? LIM_W_L'(MAX_CHANNELS) : LIM_W_L'(cfg_i.channel_count);

  always_comb begin
    phase_d  = phase_q;
    ftype_d  = ftype_q;
    biw_d    = biw_q;
    cnt_d    = cnt_q;
    dbg_d    = dbg_q;
    sum_d    = sum_q;
    asm_d    = asm_q;
    missed_d = missed_q;
    ev_valid = 1'b0;
    ev.kind   = sfd_pkg::EV_STAMP;
    ev.value  = '0;
    ev.chan   = '0;
    ev.missed = missed_q;
    ev.ok     = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PH_HEADER: begin
          missed_d = rx_byte_i[7];
          sum_d    = pc;
          biw_d    = '0;
          cnt_d    = '0;
          dbg_d    = '0;
          priority if (code == sfd_pkg::CODE_DATA) begin
            ftype_d = FT_DATA;
            if (cfg_i.on_demand) begin
              phase_d = PH_STAMP;
            end else begin
              phase_d = (limit != '0) ? PH_CHAN : PH_CHECK;
            end
          end else if (code == cfg_i.start_opcode) begin
            ftype_d = FT_START;
            phase_d = PH_CHECK;
          end else if (code == cfg_i.stop_opcode) begin
            ftype_d = FT_STOP;
            phase_d = PH_CHECK;
          end else if (code == cfg_i.debug_opcode) begin
            ftype_d = FT_DEBUG;
            phase_d = PH_DLEN;
          end else begin
            // unknown code: flag it, stay on header
            phase_d   = PH_HEADER;
            ev_valid  = 1'b1;
            ev.kind   = sfd_pkg::EV_BAD_CMD;
            ev.value  = {25'd0, code};
            ev.missed = rx_byte_i[7];
          end
        end
        PH_STAMP, PH_CHAN: begin
          sum_d = sum_plus;
          if (biw_q == 2'd3) begin
            biw_d    = '0;
            ev_valid = 1'b1;
            ev.value = {rx_byte_i, asm_q};
            if (phase_q == PH_STAMP) begin
              ev.kind = sfd_pkg::EV_STAMP;
              phase_d = (limit != '0) ? PH_CHAN : PH_CHECK;
            end else begin
              ev.kind = sfd_pkg::EV_CHAN;
              ev.chan = 3'(cnt_q);
              cnt_d   = cnt_inc;
              if (LIM_W_L'(cnt_inc) >= limit) begin
                phase_d = PH_CHECK;
              end
            end
          end else begin
            asm_d[{biw_q, 3'b000} +: 8] = rx_byte_i;
            biw_d = biw_q + 2'd1;
          end
        end
        PH_DLEN: begin
          sum_d   = sum_plus;
          dbg_d   = rx_byte_i;
          phase_d = (rx_byte_i == 8'd0) ? PH_CHECK : PH_DCHAR;
        end
        PH_DCHAR: begin
          sum_d    = sum_plus;
          dbg_d    = dbg_dec;
          if (dbg_dec == 8'd0) begin
            phase_d = PH_CHECK;
          end
          ev_valid = 1'b1;
          ev.kind  = sfd_pkg::EV_DCHAR;
          ev.value = {24'd0, rx_byte_i};
        end
        default: begin
          phase_d  = PH_HEADER;
          ev_valid = 1'b1;
          ev.ok    = (rx_byte_i == sum_q);
          unique case (ftype_q)
            FT_DATA:  ev.kind = sfd_pkg::EV_DATA_END;
            FT_START: ev.kind = sfd_pkg::EV_STRT_END;
            FT_STOP:  ev.kind = sfd_pkg::EV_STOP_END;
            default:  ev.kind = sfd_pkg::EV_DBG_END;
          endcase
        end
      endcase
    end
  end

  assign push_valid_o = ev_valid;
  assign push_data_o  = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      ftype_q  <= FT_DATA;
      biw_q    <= '0;
      cnt_q    <= '0;
      dbg_q    <= '0;
      sum_q    <= '0;
      missed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      ftype_q  <= ftype_d;
      biw_q    <= biw_d;
      cnt_q    <= cnt_d;
      dbg_q    <= dbg_d;
      sum_q    <= sum_d;
      missed_q <= missed_d;
    end
  end

  // word lanes are always written before they are read
  always_ff @(posedge clk_i) begin
    asm_q <= asm_d;
  end

endmodule

// ===== src/sfd_queue.sv =====
// Short event queue between parser and output stage.
// Depends on sfd_pkg and sample_frame_deframer_macros.svh.
`include "sample_frame_deframer_macros.svh"
module sfd_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  input  sfd_pkg::ev_t push_data_i,
  output logic         full_o,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output sfd_pkg::ev_t pop_data_o
);

  localparam int unsigned PW = sfd_pkg::Q_PTR_W;
  localparam int unsigned CW = sfd_pkg::Q_CNT_W;

  sfd_pkg::ev_t mem_q [sfd_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o      = (cnt_q == CW'(sfd_pkg::Q_DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_push     = push_valid_i && !full_o;
  assign do_pop      = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `SFD_ASSERT_NEVER(a_no_overflow, push_valid_i && full_o, "event pushed into full queue")
  `SFD_ASSERT(a_cnt_bound, cnt_q <= CW'(sfd_pkg::Q_DEPTH), "queue count out of range")
  `SFD_ASSERT(a_ptr_track, (cnt_q == '0 || cnt_q == CW'(sfd_pkg::Q_DEPTH)) |-> (wr_ptr_q == rd_ptr_q), "queue pointers disagree with count")
  `SFD_ASSERT(a_head_hold, (pop_valid_o && !pop_ready_i) |=> (pop_valid_o && $stable(pop_data_o)), "queue head changed while stalled")

endmodule

// ===== src/sfd_back.sv =====
// Output register stage: holds one event until the result channel takes it.
// Depends on sfd_pkg.
module sfd_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         pop_valid_i,
  output logic         pop_ready_o,
  input  sfd_pkg::ev_t pop_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output sfd_pkg::ev_t out_data_o
);

  logic         valid_q;
  sfd_pkg::ev_t data_q;
  logic         load;

  // refill when empty or when the held event leaves this cycle
  assign pop_ready_o = !valid_q || out_ready_i;
  assign load        = pop_ready_o && pop_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= pop_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== src/sample_frame_deframer.sv =====
// Sample frame deframer top level: config registers, parser, event queue, output stage.
// Depends on sfd_pkg, sfd_front, sfd_queue, sfd_back.
//
//  port group     dir  handshake             payload
//  rx byte in     in   in_valid_i/in_ready_o  rx_byte_i[7:0]
//  event out      out  out_valid_o/out_ready_i event_kind_o, value_word_o,
//                                             channel_index_o, sample_missed_o, checksum_ok_o
//  config (APB)   in   psel/penable/pready    paddr[4:2] = register, pwdata, prdata
//
// One byte per cycle sustained while the event queue is not full: each byte updates the frame state.
// A result enters the queue at the edge that takes its byte and moves on into the output
// register when that register is free; out_valid_o rises once it is loaded.
// in_ready_o drops only when the 2-entry event queue is full, i.e.
// after the output side has stalled. Reset is asynchronous and active low; it clears
// all control state and loads register defaults. No clearing pass after reset.
module sample_frame_deframer #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // byte input
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 rx_byte_i,
  // event output
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 event_kind_o,
  output logic [31:0]                value_word_o,
  output logic [2:0]                 channel_index_o,
  output logic                       sample_missed_o,
  output logic                       checksum_ok_o,
  // config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  sfd_pkg::cfg_t     cfg_q;
  sfd_pkg::reg_idx_e reg_idx;
  logic              cfg_wr;

  sfd_pkg::ev_t push_data, pop_data, out_data;
  logic         push_valid, q_full, pop_valid, pop_ready;

  // ---------------------------------------------------------------------------
  // Config registers: written on the APB access phase, always ready; read live by the parser.
  // Writes are to come only while idle; the block itself does not enforce this.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = sfd_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= sfd_pkg::CHAN_CNT_RST;
      cfg_q.on_demand     <= 1'b0;
      cfg_q.start_opcode  <= sfd_pkg::START_OP_RST;
      cfg_q.stop_opcode   <= sfd_pkg::STOP_OP_RST;
      cfg_q.debug_opcode  <= sfd_pkg::DEBUG_OP_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sfd_pkg::REG_CHAN_CNT:  cfg_q.channel_count <= pwdata[3:0];
        sfd_pkg::REG_ON_DEMAND: cfg_q.on_demand     <= pwdata[0];
        sfd_pkg::REG_START_OP:  cfg_q.start_opcode  <= pwdata[6:0];
        sfd_pkg::REG_STOP_OP:   cfg_q.stop_opcode   <= pwdata[6:0];
        sfd_pkg::REG_DEBUG_OP:  cfg_q.debug_opcode  <= pwdata[6:0];
        default: ;  // unmapped: write ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sfd_pkg::REG_CHAN_CNT:  prdata = {28'd0, cfg_q.channel_count};
      sfd_pkg::REG_ON_DEMAND: prdata = {31'd0, cfg_q.on_demand};
      sfd_pkg::REG_START_OP:  prdata = {25'd0, cfg_q.start_opcode};
      sfd_pkg::REG_STOP_OP:   prdata = {25'd0, cfg_q.stop_opcode};
      sfd_pkg::REG_DEBUG_OP:  prdata = {25'd0, cfg_q.debug_opcode};
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front: byte parser. Every accepted byte updates the frame state; bytes that
  // complete a word, a debug char, a frame or a bad command push one event.
  // ---------------------------------------------------------------------------
  sfd_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg_q),
    .q_full_i    (q_full),
    .push_valid_o(push_valid),
    .push_data_o (push_data)
  );

  // Event queue decouples parser from the output stall.
  sfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  // Back: registered output transaction.
  sfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data)
  );

  assign event_kind_o    = out_data.kind;
  assign value_word_o    = out_data.value;
  assign channel_index_o = out_data.chan;
  assign sample_missed_o = out_data.missed;
  assign checksum_ok_o   = out_data.ok;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for sample_frame_deframer: directed byte table, then random frame traffic.
// Depends on sfd_pkg and the RTL; expected events are hand-typed or from an in-bench parser.

module tb;

  localparam int MaxChan = 8;

  typedef enum logic [2:0] {P_HEAD, P_STAMP, P_CHAN, P_DLEN, P_DCHAR, P_CHECK} parse_phase_e;
  typedef enum logic [1:0] {F_DATA, F_START, F_STOP, F_DEBUG} frame_e;

  typedef struct {
    logic [7:0]   b;
    bit           typed;  // expected event written in by hand
    sfd_pkg::ev_t ev;
  } stim_row_t;

  localparam sfd_pkg::ev_t NoEv = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  event_kind_o;
  logic [31:0] value_word_o;
  logic [2:0]  channel_index_o;
  logic        sample_missed_o;
  logic        checksum_ok_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [sfd_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sample_frame_deframer #(.MAX_CHANNELS(MaxChan)) uut (.*);

  // parser shadow state, updated once per accepted byte
  sfd_pkg::cfg_t cfg;
  parse_phase_e  ph;
  frame_e        ft;
  logic [1:0]    biw;
  logic [4:0]    chan_ctr;
  logic [7:0]    dbg_left;
  logic [7:0]    csum;
  logic [23:0]   asm_word;
  logic          missed_hdr;

  sfd_pkg::ev_t owed_events[$];
  stim_row_t    dir_tab[$];
  logic [7:0]   frame_buf[$];
  int           errors = 0;
  int           bytes_sent = 0;
  int           events_seen = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // hard stop in case the handshake hangs
  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic sfd_pkg::ev_t mk_ev(sfd_pkg::ev_kind_e k, logic [31:0] v, logic [2:0] c,
                                         logic m, logic ok);
    sfd_pkg::ev_t e;
    e.kind = k;
    e.value = v;
    e.chan = c;
    e.missed = m;
    e.ok = ok;
    return e;
  endfunction

  // little-endian word assembly; returns 1 on the fourth byte
  function automatic bit take_byte(input logic [7:0] b, output logic [31:0] w);
    w = '0;
    if (biw == 2'd3) begin
      w = {b, asm_word};
      biw = 2'd0;
      asm_word = '0;
      return 1'b1;
    end
    asm_word = asm_word | (24'(b) << (8 * biw));
    biw = biw + 2'd1;
    return 1'b0;
  endfunction

  // advance the shadow parser by one byte; returns 1 when an event is due
  function automatic bit deframe_byte(input logic [7:0] b, output sfd_pkg::ev_t ev);
    logic [4:0]  lim;
    logic [31:0] w;
    logic [4:0]  idx;
    lim = (cfg.channel_count > MaxChan) ? 5'(MaxChan) : 5'(cfg.channel_count);
    ev = NoEv;
    // the checksum byte itself is not summed
    if (ph != P_HEAD && ph != P_CHECK) csum = csum + 8'($countones(b));
    case (ph)
      P_HEAD: begin
        missed_hdr = b[7];
        csum = 8'($countones(b));
        biw = '0;
        asm_word = '0;
        chan_ctr = '0;
        dbg_left = '0;
        if (b[6:0] == sfd_pkg::CODE_DATA) begin
          ft = F_DATA;
          ph = cfg.on_demand ? P_STAMP : ((lim > 0) ? P_CHAN : P_CHECK);
        end else if (b[6:0] == cfg.start_opcode) begin
          ft = F_START;
          ph = P_CHECK;
        end else if (b[6:0] == cfg.stop_opcode) begin
          ft = F_STOP;
          ph = P_CHECK;
        end else if (b[6:0] == cfg.debug_opcode) begin
          ft = F_DEBUG;
          ph = P_DLEN;
        end else begin
          // unknown code: flagged, parser keeps hunting for a header
          ev = mk_ev(sfd_pkg::EV_BAD_CMD, 32'(b[6:0]), 3'd0, missed_hdr, 1'b0);
          return 1'b1;
        end
        return 1'b0;
      end
      P_STAMP: begin
        if (!take_byte(b, w)) return 1'b0;
        ph = (lim > 0) ? P_CHAN : P_CHECK;
        ev = mk_ev(sfd_pkg::EV_STAMP, w, 3'd0, missed_hdr, 1'b0);
        return 1'b1;
      end
      P_CHAN: begin
        if (!take_byte(b, w)) return 1'b0;
        idx = chan_ctr;
        chan_ctr = chan_ctr + 5'd1;
        // count is read live, so a shrink mid-frame jumps to the checksum
        if (chan_ctr >= lim) ph = P_CHECK;
        ev = mk_ev(sfd_pkg::EV_CHAN, w, idx[2:0], missed_hdr, 1'b0);
        return 1'b1;
      end
      P_DLEN: begin
        dbg_left = b;
        ph = (b == 8'd0) ? P_CHECK : P_DCHAR;
        return 1'b0;
      end
      P_DCHAR: begin
        dbg_left = dbg_left - 8'd1;
        if (dbg_left == 8'd0) ph = P_CHECK;
        ev = mk_ev(sfd_pkg::EV_DCHAR, 32'(b), 3'd0, missed_hdr, 1'b0);
        return 1'b1;
      end
      default: begin
        ph = P_HEAD;
        ev = mk_ev(sfd_pkg::ev_kind_e'(3'(sfd_pkg::EV_DATA_END) + 3'(ft)), 32'd0, 3'd0,
                   missed_hdr, b == csum);
        return 1'b1;
      end
    endcase
  endfunction

  // Offer one byte, with random gaps; entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input bit typed, input sfd_pkg::ev_t tev);
    sfd_pkg::ev_t pev;
    bit  has;
    bit  no_gap;
    no_gap = (bytes_sent >= 600) && (bytes_sent < 800);
    while (!no_gap && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    has = deframe_byte(b, pev);
    if (typed) owed_events.insert(owed_events.size(), tev);
    else if (has) owed_events.insert(owed_events.size(), pev);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // APB write plus read-back; only called with the block drained
  task automatic reg_write(input sfd_pkg::reg_idx_e idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      sfd_pkg::REG_CHAN_CNT:  cfg.channel_count = val[3:0];
      sfd_pkg::REG_ON_DEMAND: cfg.on_demand = val[0];
      sfd_pkg::REG_START_OP:  cfg.start_opcode = val[6:0];
      sfd_pkg::REG_STOP_OP:   cfg.stop_opcode = val[6:0];
      default:                cfg.debug_opcode = val[6:0];
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata != val) begin
      $error("prdata reg %0d expected %0h actual %0h", idx, val, prdata);
      errors++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait for every owed event, then cover the output pipeline latency
  task automatic wait_drained();
    while (owed_events.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // One random frame under the current settings, sometimes corrupted or cut short.
  task automatic gen_frame();
    int         sel;
    int         nw;
    int         dl;
    logic       miss;
    logic [7:0] sum;
    frame_buf.delete();
    sel = $urandom_range(99);
    miss = 1'($urandom_range(1));
    if (sel < 10) begin
      // line noise
      repeat ($urandom_range(3, 1)) frame_buf.insert(frame_buf.size(), 8'($urandom));
      return;
    end
    if (sel < 55) begin
      frame_buf.insert(frame_buf.size(), {miss, sfd_pkg::CODE_DATA});
      nw = (cfg.on_demand ? 1 : 0) + ((cfg.channel_count > MaxChan) ? MaxChan :
                                      int'(cfg.channel_count));
      repeat (4 * nw) frame_buf.insert(frame_buf.size(), 8'($urandom));
    end else if (sel < 70) begin
      frame_buf.insert(frame_buf.size(), {miss, cfg.start_opcode});
    end else if (sel < 80) begin
      frame_buf.insert(frame_buf.size(), {miss, cfg.stop_opcode});
    end else begin
      frame_buf.insert(frame_buf.size(), {miss, cfg.debug_opcode});
      dl = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(6);
      frame_buf.insert(frame_buf.size(), 8'(dl));
      repeat (dl) frame_buf.insert(frame_buf.size(), 8'($urandom));
    end
    sum = '0;
    foreach (frame_buf[i]) sum = sum + 8'($countones(frame_buf[i]));
    if ($urandom_range(9) == 0) sum = sum ^ 8'($urandom_range(255, 1));
    frame_buf.insert(frame_buf.size(), sum);
    if ($urandom_range(19) == 0)
      frame_buf = frame_buf[0:$urandom_range(frame_buf.size() - 1)];
  endtask

  // Result side: random stalls, one long hold-off to back the block up,
  // and a stretch with no stalls at all.
  initial begin
    int hold;
    bit pressed;
    hold = 0;
    pressed = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else if (!pressed && events_seen >= 150) begin
        pressed = 1'b1;
        hold = 99;
        out_ready_i <= 1'b0;
      end else if (events_seen >= 250 && events_seen < 350) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 38);
      end
    end
  end

  // Compare each accepted result transaction with the oldest owed event.
  always @(posedge clk_i) begin
    sfd_pkg::ev_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      events_seen++;
      if (owed_events.size() == 0) begin
        $error("unexpected event kind %0d value %0h", event_kind_o, value_word_o);
        errors++;
      end else begin
        e = owed_events.pop_front();
        if (event_kind_o != e.kind) begin
          $error("event_kind expected %0d actual %0d", e.kind, event_kind_o);
          errors++;
        end
        if (value_word_o != e.value) begin
          $error("value_word expected %0h actual %0h", e.value, value_word_o);
          errors++;
        end
        if (channel_index_o != e.chan) begin
          $error("channel_index expected %0d actual %0d", e.chan, channel_index_o);
          errors++;
        end
        if (sample_missed_o != e.missed) begin
          $error("sample_missed expected %0d actual %0d", e.missed, sample_missed_o);
          errors++;
        end
        if (checksum_ok_o != e.ok) begin
          $error("checksum_ok expected %0d actual %0d", e.ok, checksum_ok_o);
          errors++;
        end
      end
    end
  end

  initial begin
    sfd_pkg::cfg_t nc;
    int            phase_bytes;
    int            cut;
    cfg = '{sfd_pkg::CHAN_CNT_RST, 1'b0, sfd_pkg::START_OP_RST, sfd_pkg::STOP_OP_RST,
            sfd_pkg::DEBUG_OP_RST};
    ph = P_HEAD;
    ft = F_DATA;
    biw = '0;
    chan_ctr = '0;
    dbg_left = '0;
    csum = '0;
    asm_word = '0;
    missed_hdr = 1'b0;

    // Directed bytes under reset settings (1 channel, no timestamp, opcodes 1/2/3).
    dir_tab = '{
      '{8'h05, 1'b1, mk_ev(sfd_pkg::EV_BAD_CMD, 32'h05, 3'd0, 1'b0, 1'b0)},  // unknown code
      '{8'hFF, 1'b1, mk_ev(sfd_pkg::EV_BAD_CMD, 32'h7F, 3'd0, 1'b1, 1'b0)},  // all ones
      '{8'h81, 1'b0, NoEv},                                                  // start, missed
      '{8'h02, 1'b1, mk_ev(sfd_pkg::EV_STRT_END, 32'd0, 3'd0, 1'b1, 1'b1)},
      '{8'h02, 1'b0, NoEv},                                                  // stop
      '{8'h00, 1'b1, mk_ev(sfd_pkg::EV_STOP_END, 32'd0, 3'd0, 1'b0, 1'b0)},  // bad checksum
      '{8'h00, 1'b0, NoEv},                                                  // data
      '{8'hFF, 1'b0, NoEv},
      '{8'h00, 1'b0, NoEv},
      '{8'h80, 1'b0, NoEv},
      '{8'h7F, 1'b1, mk_ev(sfd_pkg::EV_CHAN, 32'h7F8000FF, 3'd0, 1'b0, 1'b0)},
      '{8'h10, 1'b1, mk_ev(sfd_pkg::EV_DATA_END, 32'd0, 3'd0, 1'b0, 1'b1)},
      '{8'h03, 1'b0, NoEv},                                                  // debug, empty
      '{8'h00, 1'b0, NoEv},
      '{8'h02, 1'b1, mk_ev(sfd_pkg::EV_DBG_END, 32'd0, 3'd0, 1'b0, 1'b1)},
      '{8'h83, 1'b0, NoEv},                                                  // debug, 2 chars
      '{8'h02, 1'b0, NoEv},
      '{8'h41, 1'b1, mk_ev(sfd_pkg::EV_DCHAR, 32'h41, 3'd0, 1'b1, 1'b0)},
      '{8'hFF, 1'b1, mk_ev(sfd_pkg::EV_DCHAR, 32'hFF, 3'd0, 1'b1, 1'b0)},
      '{8'h0E, 1'b1, mk_ev(sfd_pkg::EV_DBG_END, 32'd0, 3'd0, 1'b1, 1'b1)},
      '{8'h80, 1'b0, NoEv},                                                  // data, missed
      '{8'h01, 1'b0, NoEv},
      '{8'h02, 1'b0, NoEv},
      '{8'h03, 1'b0, NoEv},
      '{8'h04, 1'b0, NoEv},
      '{8'hFF, 1'b1, mk_ev(sfd_pkg::EV_DATA_END, 32'd0, 3'd0, 1'b1, 1'b0)}
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].ev);
    in_valid_i <= 1'b0;
    wait_drained();

    // Random phases, each under its own settings; extremes come first.
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       nc = '{4'd0, 1'b0, 7'd1, 7'd2, 7'd3};         // header straight to checksum
        1:       nc = '{4'd8, 1'b1, 7'd127, 7'd126, 7'd125};
        2:       nc = '{4'd15, 1'b0, 7'd127, 7'd127, 7'd127};  // clamp, all codes equal
        3:       nc = '{4'd0, 1'b1, 7'd5, 7'd5, 7'd9};         // timestamp only
        default: nc = '{4'($urandom_range(15)), 1'($urandom_range(1)),
                        7'($urandom_range(127, 1)), 7'($urandom_range(127, 1)),
                        7'($urandom_range(127, 1))};
      endcase
      reg_write(sfd_pkg::REG_CHAN_CNT, 32'(nc.channel_count));
      reg_write(sfd_pkg::REG_ON_DEMAND, 32'(nc.on_demand));
      reg_write(sfd_pkg::REG_START_OP, 32'(nc.start_opcode));
      reg_write(sfd_pkg::REG_STOP_OP, 32'(nc.stop_opcode));
      reg_write(sfd_pkg::REG_DEBUG_OP, 32'(nc.debug_opcode));

      phase_bytes = 0;
      while (phase_bytes < 95) begin
        gen_frame();
        foreach (frame_buf[i]) send_byte(frame_buf[i], 1'b0, NoEv);
        phase_bytes += frame_buf.size();
      end
      // often leave a frame open so the next settings land mid-frame
      if ($urandom_range(1)) begin
        gen_frame();
        cut = (frame_buf.size() + 1) / 2;
        for (int i = 0; i < cut; i++) send_byte(frame_buf[i], 1'b0, NoEv);
      end
      in_valid_i <= 1'b0;
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
